// ----- rtl/esmc_pkg.sv -----
// ---------------------------------------------------------------------------
// esmc_pkg
// Shared widths, constants and the control/status bundles that connect the
// controller and the datapath of the edge scatter min/count core.
// ---------------------------------------------------------------------------
package esmc_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned NCNT_W  = 11;
  localparam int unsigned ENTRY_W = VALUE_W + COUNT_W;

  // Input tdata: edge_value, first_node, second_node (56 bits, whole bytes)
  localparam int unsigned IN_DATA_W  = 56;
  // Output tdata: status, node_minimum, node_edges (49 bits padded to 56)
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [VALUE_W-1:0] MIN_CLEAR  = 32'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [NCNT_W-1:0]  NCNT_RESET = 11'd1024;

  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch an accepted request
    logic rd_first;   // issue a store read for the first node
    logic rd_second;  // issue a store read for the second node
    logic wr_first;   // write back the first node entry
    logic wr_second;  // write back the second node entry
    logic clear_wr;   // write one entry of the post-reset clearing pass
    logic load_out;   // load the result into the output register
  } esmc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_bad;     // request has an out-of-range node index
    logic is_read;     // request is a read-and-clear
    logic self_edge;   // both node indices are equal
    logic clear_last;  // clearing pass is at its last entry
  } esmc_sts_t;

endpackage

// ----- rtl/esmc_ctrl.sv -----
// ---------------------------------------------------------------------------
// esmc_ctrl
// Controller state machine: clearing pass after reset, request sequencing
// over the node store, and the output valid register.
// ---------------------------------------------------------------------------
module esmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  esmc_pkg::esmc_sts_t sts,
  output esmc_pkg::esmc_cmd_t cmd
);
  import esmc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_A,
    ST_UPD_A,
    ST_UPD_B,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ_A;
        end
      end
      ST_READ_A: begin
        if (sts.idx_bad) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = ST_UPD_A;
        end
      end
      ST_UPD_A: begin
        cmd.wr_first = 1'b1;
        if (!sts.is_read && !sts.self_edge) begin
          cmd.rd_second = 1'b1;
          state_nxt     = ST_UPD_B;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_UPD_B: begin
        cmd.wr_second = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_rd_first_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_first |=> cmd.wr_first)
    else $error("first node read not followed by its write-back");

  a_rd_second_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_second |=> cmd.wr_second)
    else $error("second node read not followed by its write-back");

  a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_bad_skips_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ_A && sts.idx_bad) |=> (state_r == ST_DONE && !cmd.wr_first))
    else $error("bad index request touched the store");

endmodule

// ----- rtl/esmc_dp.sv -----
// ---------------------------------------------------------------------------
// esmc_dp
// Datapath: request registers, index range check, node store with one
// write and one registered read port, min/count update and output register.
// ---------------------------------------------------------------------------
module esmc_dp #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_mode,
  input  logic [esmc_pkg::IN_DATA_W-1:0]     in_data,
  input  logic                               cfg_wr_en,
  input  logic [esmc_pkg::NCNT_W-1:0]        cfg_wr_data,
  input  esmc_pkg::esmc_cmd_t                cmd,
  output esmc_pkg::esmc_sts_t                sts,
  output logic [esmc_pkg::OUT_DATA_W-1:0]    out_data
);
  import esmc_pkg::*;

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [INDEX_W:0] NODE_LIM = (INDEX_W + 1)'(MAX_NODES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  logic [NCNT_W-1:0]  node_count_r;
  logic [AW-1:0]      clr_addr_r;
  logic               mode_r;
  logic               idx_bad_r;
  logic               self_r;
  logic [VALUE_W-1:0] value_r;
  logic [AW-1:0]      a_addr_r, b_addr_r;
  logic [VALUE_W-1:0] res_min_r;
  logic [COUNT_W-1:0] res_cnt_r;
  logic               res_status_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [ENTRY_W-1:0] mem_r [MAX_NODES];
  logic [ENTRY_W-1:0] rdata_r;

  logic [INDEX_W-1:0] in_a, in_b;
  logic               a_ok, b_ok;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               we;
  logic [ENTRY_W-1:0] wdata, upd_entry;
  logic [VALUE_W-1:0] rd_min, new_min;
  logic [COUNT_W-1:0] rd_cnt;
  logic [COUNT_W:0]   cnt_sum;

  assign in_a = in_data[VALUE_W +: INDEX_W];
  assign in_b = in_data[VALUE_W + INDEX_W +: INDEX_W];

  // Range check against node_count, capped at the store depth
  assign a_ok = (in_a != '0) && ({1'b0, in_a} <= {2'b00, node_count_r})
                && ({1'b0, in_a} <= NODE_LIM);
  assign b_ok = (in_b != '0) && ({1'b0, in_b} <= {2'b00, node_count_r})
                && ({1'b0, in_b} <= NODE_LIM);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCNT_RESET;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_mode;
      value_r   <= in_data[VALUE_W-1:0];
      self_r    <= (in_a == in_b);
      idx_bad_r <= !a_ok || ((in_mode == MODE_ACCUM) && !b_ok);
      a_addr_r  <= AW'(in_a - 1'b1);
      b_addr_r  <= AW'(in_b - 1'b1);
    end
  end

  // Entry update: running minimum and saturating count
  assign rd_min  = rdata_r[VALUE_W-1:0];
  assign rd_cnt  = rdata_r[VALUE_W +: COUNT_W];
  assign new_min = ($signed(value_r) < $signed(rd_min)) ? value_r : rd_min;
  assign cnt_sum = {1'b0, rd_cnt} + (self_r ? (COUNT_W + 1)'(2) : (COUNT_W + 1)'(1));
  assign upd_entry = {(cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0]), new_min};

  // Store port selection
  always_comb begin
    rd_addr = cmd.rd_second ? b_addr_r : a_addr_r;
    we      = cmd.clear_wr || cmd.wr_first || cmd.wr_second;
    wr_addr = a_addr_r;
    wdata   = upd_entry;
    if (cmd.clear_wr) begin
      wr_addr = clr_addr_r;
      wdata   = {{COUNT_W{1'b0}}, MIN_CLEAR};
    end else if (cmd.wr_second) begin
      wr_addr = b_addr_r;
    end else if (mode_r == MODE_READ) begin
      wdata   = {{COUNT_W{1'b0}}, MIN_CLEAR};
    end
  end

  // Node store
  always_ff @(posedge clk) begin
    if (we) mem_r[wr_addr] <= wdata;
    rdata_r <= mem_r[rd_addr];
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_min_r <= '0;
      res_cnt_r <= '0;
    end else if (cmd.wr_first && mode_r == MODE_READ) begin
      res_min_r <= rd_min;
      res_cnt_r <= rd_cnt;
    end
    res_status_r <= idx_bad_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {{(OUT_DATA_W - 1 - VALUE_W - COUNT_W){1'b0}},
                     res_cnt_r, res_min_r, res_status_r};
    end
  end

  assign out_data = out_data_r;

  assign sts.idx_bad    = idx_bad_r;
  assign sts.is_read    = (mode_r == MODE_READ);
  assign sts.self_edge  = self_r;
  assign sts.clear_last = (clr_addr_r == LAST_ADDR);

endmodule

// ----- rtl/edge_scatter_min_count_core.sv -----
// Sequence: a bad index passes READ_A and DONE, a read or a self-edge
//   READ_A, UPD_A and DONE, a two-node edge READ_A, UPD_A, UPD_B and DONE.
// Flow: one request at a time, set by the sequential read-modify-write of
//   each entry through the single store port pair; DONE awaits a free output.
// Reset: synchronous; a clearing pass over all MAX_NODES entries follows, with no
//   request accepted (configuration writes are taken throughout).
// ---------------------------------------------------------------------------
// edge_scatter_min_count_core
// Per-node scatter reduction: running minimum and saturating edge count per
// node, with read-and-clear of one node.
// ---------------------------------------------------------------------------
module edge_scatter_min_count_core #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [esmc_pkg::IN_DATA_W-1:0]    in_tdata,  // edge_value[31:0], first_node[43:32],
                                                       // second_node[55:44]
  input  logic                              in_tuser,  // mode
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [esmc_pkg::OUT_DATA_W-1:0]   out_tdata, // status[0], node_minimum[32:1],
                                                       // node_edges[48:33], zero above
  // Configuration
  input  logic                              cfg_wr_en,
  input  logic [esmc_pkg::NCNT_W-1:0]       cfg_wr_data // node_count
);
  import esmc_pkg::*;

  esmc_cmd_t cmd;
  esmc_sts_t sts;

  // Sequencer
  esmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Store and arithmetic
  esmc_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_tuser),
    .in_data     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_tdata)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge scatter min/count core. A request queue
// feeds a stream driver, and a monitor predicts each accepted request against
// a shadow copy of the per-node minimum and count stores. It then checks
// every result, field by field, in order. Both sides stall at random, and
// one phase holds off the result side long enough to back up the input.
// ---------------------------------------------------------------------------
module tb_top;

  import esmc_pkg::*;

  localparam int unsigned NODES        = 1024;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic        STATUS_OK    = 1'b0;
  localparam logic        STATUS_BAD   = 1'b1;

  typedef struct {
    logic        mode;
    logic [31:0] value;
    logic [11:0] first_node;
    logic [11:0] second_node;
  } edge_req_t;

  typedef struct {
    logic        status;
    logic [31:0] minimum;
    logic [15:0] edges;
  } node_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [NCNT_W-1:0]     cfg_wr_data = '0;

  // Shadow state of the core
  logic [31:0]  min_shadow [NODES];
  logic [15:0]  count_shadow [NODES];
  int unsigned  node_count_shadow;

  edge_req_t    pending_reqs [$];
  node_result_t expected_results [$];
  edge_req_t    drive_req;
  edge_req_t    seen_req;
  node_result_t seen_result;
  node_result_t want_result;

  int unsigned  send_gap    = 0;
  int unsigned  recv_gap    = 0;
  bit           gaps_on     = 1'b0;
  bit           pressure_go = 1'b0;
  logic         hold_off    = 1'b0;
  int unsigned  fail_count  = 0;

  edge_scatter_min_count_core #(
    .MAX_NODES(NODES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while gaps are switched off
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit node_in_range(logic [11:0] idx);
    int unsigned active;
    active = (node_count_shadow > NODES) ? NODES : node_count_shadow;
    return (idx >= 1) && (idx <= active);
  endfunction

  function automatic void take_minimum(int unsigned slot, logic [31:0] value);
    if ($signed(value) < $signed(min_shadow[slot])) min_shadow[slot] = value;
  endfunction

  function automatic void bump_count(int unsigned slot, int unsigned amount);
    int unsigned sum;
    sum = count_shadow[slot] + amount;
    count_shadow[slot] = (sum > COUNT_MAX) ? COUNT_MAX : sum[15:0];
  endfunction

  // Update the shadow stores for one accepted request and queue its result
  function automatic void scatter_predict(edge_req_t req);
    node_result_t res;
    int unsigned  slot;
    res = '{STATUS_OK, 32'd0, 16'd0};
    if (req.mode == MODE_READ) begin
      if (!node_in_range(req.first_node)) begin
        res.status = STATUS_BAD;
      end else begin
        slot = req.first_node - 1;
        res.minimum = min_shadow[slot];
        res.edges = count_shadow[slot];
        min_shadow[slot] = MIN_CLEAR;
        count_shadow[slot] = '0;
      end
    end else if (!node_in_range(req.first_node) || !node_in_range(req.second_node)) begin
      res.status = STATUS_BAD;
    end else if (req.first_node == req.second_node) begin
      take_minimum(req.first_node - 1, req.value);
      bump_count(req.first_node - 1, 2);
    end else begin
      take_minimum(req.first_node - 1, req.value);
      take_minimum(req.second_node - 1, req.value);
      bump_count(req.first_node - 1, 1);
      bump_count(req.second_node - 1, 1);
    end
    expected_results.push_back(res);
  endfunction

  // Drive requests from the pending queue, with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        drive_req = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {drive_req.second_node, drive_req.first_node, drive_req.value};
        in_tuser <= drive_req.mode;
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, and hold it off during a pressure window
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      out_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready) recv_gap <= pick_gap();
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_req.mode = in_tuser;
        seen_req.value = in_tdata[31:0];
        seen_req.first_node = in_tdata[43:32];
        seen_req.second_node = in_tdata[55:44];
        scatter_predict(seen_req);
      end
      if (out_tvalid && out_tready) begin
        seen_result.status = out_tdata[0];
        seen_result.minimum = out_tdata[32:1];
        seen_result.edges = out_tdata[48:33];
        if (expected_results.size() == 0) begin
          $error("result with no request pending: tdata %h", out_tdata);
          fail_count++;
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result.status !== want_result.status) begin
            $error("status: expected %0d, got %0d", want_result.status, seen_result.status);
            fail_count++;
          end
          if (seen_result.minimum !== want_result.minimum) begin
            $error("node_minimum: expected %h, got %h",
                   want_result.minimum, seen_result.minimum);
            fail_count++;
          end
          if (seen_result.edges !== want_result.edges) begin
            $error("node_edges: expected %0d, got %0d", want_result.edges, seen_result.edges);
            fail_count++;
          end
        end
      end
    end
  end

  // Hold off the result side for a long stretch once asked
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic queue_edge(logic [31:0] value, logic [11:0] a, logic [11:0] b);
    pending_reqs.push_back('{MODE_ACCUM, value, a, b});
  endtask

  // Unused fields carry random junk on reads
  task automatic queue_read(logic [11:0] a);
    pending_reqs.push_back('{MODE_READ, $urandom, a, 12'($urandom_range(0, 4095))});
  endtask

  // Wait until every request is sent and every result is back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_node_count(int unsigned value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[NCNT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_count_shadow = value;
  endtask

  function automatic logic [11:0] pick_node();
    int unsigned r;
    int unsigned active;
    active = (node_count_shadow > NODES) ? NODES : node_count_shadow;
    r = $urandom_range(0, 99);
    if (r < 5) return 12'd0;
    if (r < 10 || active == 0) return 12'($urandom_range(0, 4095));
    if (r < 15) return 12'(active + 1);
    if (r < 70) return 12'($urandom_range(1, (active < 8) ? active : 8));
    return 12'($urandom_range(1, active));
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h8000_0000;
    if (r < 20) return MIN_CLEAR;
    if (r < 40) return $urandom_range(0, 200) - 100;
    return $urandom;
  endfunction

  // One random phase at a given node count; reads are about a quarter
  task automatic run_phase(int unsigned ncount, int unsigned items, bit gaps, bit stall_out);
    write_node_count(ncount);
    gaps_on = gaps;
    if (stall_out) pressure_go = 1'b1;
    repeat (items) begin
      if ($urandom_range(0, 3) == 0) queue_read(pick_node());
      else queue_edge(pick_value(), pick_node(), pick_node());
    end
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      min_shadow[i] = MIN_CLEAR;
      count_shadow[i] = '0;
    end
    node_count_shadow = NCNT_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, self-edges, the cleared mark as a value, bad indices
    write_node_count(NODES);
    queue_edge(32'h8000_0000, 12'd1, 12'd1024);
    queue_read(12'd1);
    queue_read(12'd1024);
    queue_read(12'd1);
    queue_edge(MIN_CLEAR, 12'd5, 12'd5);
    queue_read(12'd5);
    queue_edge(MIN_CLEAR, 12'd7, 12'd8);
    queue_edge(32'h0001_8000, 12'd7, 12'd9);
    queue_edge(32'hFFFF_FFFF, 12'd8, 12'd8);
    queue_read(12'd7);
    queue_read(12'd8);
    queue_edge(32'd5, 12'd0, 12'd3);
    queue_edge(32'd5, 12'd3, 12'd1025);
    queue_edge(32'd5, 12'd4095, 12'd2);
    queue_edge(32'd5, 12'd0, 12'd0);
    queue_read(12'd0);
    queue_read(12'd1025);
    queue_read(12'd4095);
    queue_read(12'd3);
    queue_read(12'd2);
    queue_read(12'd9);
    queue_read(12'd100);

    // Random phases over several node counts, including zero and above capacity
    run_phase(16, 150, 1'b0, 1'b1);
    run_phase(1, 80, 1'b1, 1'b0);
    run_phase(2, 80, 1'b1, 1'b0);
    run_phase(0, 40, 1'b1, 1'b0);
    run_phase(2047, 120, 1'b1, 1'b0);
    run_phase(1025, 80, 1'b0, 1'b0);

    // Pile self-edges onto node 1, mix in a plain edge, then read both back
    write_node_count(2);
    gaps_on = 1'b0;
    repeat (60) queue_edge(pick_value(), 12'd1, 12'd1);
    queue_edge(pick_value(), 12'd1, 12'd2);
    queue_edge(pick_value(), 12'd1, 12'd1);
    queue_read(12'd1);
    queue_read(12'd2);

    run_phase(3, 80, 1'b1, 1'b0);
    run_phase(NODES, 200, 1'b1, 1'b0);
    run_phase($urandom_range(1, NODES), 150, 1'b1, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/esmc_pkg.sv
rtl/esmc_ctrl.sv
rtl/esmc_dp.sv
rtl/edge_scatter_min_count_core.sv
tb/sv/tb_top.sv
